@@ sv/bfha_pkg.sv @@
package bfha_pkg;

  // heap geometry
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int ALIGN_MASK   = ALIGN_BYTES - 1;
  localparam int ALIGN_SH     = $clog2(ALIGN_BYTES);
  localparam int SLOTS        = HEAP_BYTES / ALIGN_BYTES;
  localparam int SLOT_W       = $clog2(SLOTS);

  // request kinds
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  // datapath commands
  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NOP       = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD      = 5'd1;
  localparam logic [CMD_W-1:0] CMD_V_INIT    = 5'd2;
  localparam logic [CMD_W-1:0] CMD_RD_H      = 5'd3;
  localparam logic [CMD_W-1:0] CMD_V_EQ      = 5'd4;
  localparam logic [CMD_W-1:0] CMD_H_ADV     = 5'd5;
  localparam logic [CMD_W-1:0] CMD_ALLOC_SET = 5'd6;
  localparam logic [CMD_W-1:0] CMD_A_INIT    = 5'd7;
  localparam logic [CMD_W-1:0] CMD_A_EVAL    = 5'd8;
  localparam logic [CMD_W-1:0] CMD_TAKE_RD   = 5'd9;
  localparam logic [CMD_W-1:0] CMD_TAKE_WR   = 5'd10;
  localparam logic [CMD_W-1:0] CMD_EXT_WR    = 5'd11;
  localparam logic [CMD_W-1:0] CMD_EXT_FAIL  = 5'd12;
  localparam logic [CMD_W-1:0] CMD_S_RD      = 5'd13;
  localparam logic [CMD_W-1:0] CMD_S_WR      = 5'd14;
  localparam logic [CMD_W-1:0] CMD_S_NEW     = 5'd15;
  localparam logic [CMD_W-1:0] CMD_L_RD1     = 5'd16;
  localparam logic [CMD_W-1:0] CMD_L_RD2     = 5'd17;
  localparam logic [CMD_W-1:0] CMD_L_WR      = 5'd18;
  localparam logic [CMD_W-1:0] CMD_M_RD1     = 5'd19;
  localparam logic [CMD_W-1:0] CMD_M_RD2     = 5'd20;
  localparam logic [CMD_W-1:0] CMD_M_WR      = 5'd21;
  localparam logic [CMD_W-1:0] CMD_RD_TGT    = 5'd22;
  localparam logic [CMD_W-1:0] CMD_R_WR      = 5'd23;
  localparam logic [CMD_W-1:0] CMD_RD_PREV   = 5'd24;
  localparam logic [CMD_W-1:0] CMD_RE_SHR    = 5'd25;
  localparam logic [CMD_W-1:0] CMD_RE_MOV    = 5'd26;
  localparam logic [CMD_W-1:0] CMD_MV_OK     = 5'd27;
  localparam logic [CMD_W-1:0] CMD_OUT       = 5'd28;

  // one block header as kept in the header memory
  typedef struct packed {
    logic [16:0] size;
    logic        used;
    logic [15:0] prev;
    logic        pv;
  } hdr_t;

  // datapath status toward the controller
  typedef struct packed {
    logic [1:0] op;
    logic       pv;
    logic       vld;
    logic       rs_zero;
    logic       v_skip;
    logic       h_in;
    logic       h_gt;
    logic       h_eq;
    logic       rd_used;
    logic       rd_small;
    logic       rd_pv;
    logic       found;
    logic       areq_zero;
    logic       brk_hdr;
    logic       ext_fit;
    logic       split_ok;
    logic       last_is_sx;
    logic       lk_ok1;
    logic       lk_ok2;
    logic       mg_ok1;
    logic       mg_ok2;
    logic       last_is_mn;
    logic       fits;
    logic       ok;
    logic       out_busy;
  } dp_sts_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [15:0] off);
    slot_of = off[ALIGN_SH +: SLOT_W];
  endfunction

  function automatic logic [18:0] rnd_up(input logic [18:0] x);
    rnd_up = (x + 19'(ALIGN_MASK)) & ~19'(ALIGN_MASK);
  endfunction

endpackage

@@ sv/bfha_ram.sv @@
module bfha_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wd,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    if (re) begin
      rd <= mem[addr];
    end
  end

endmodule

@@ sv/bfha_ctrl.sv @@
module bfha_ctrl
  import bfha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  dp_sts_t          sts,
  output logic             in_stall,
  output logic [CMD_W-1:0] cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_VINIT  = 5'd1;
  localparam logic [4:0] S_VTEST  = 5'd2;
  localparam logic [4:0] S_VREAD  = 5'd3;
  localparam logic [4:0] S_DISP   = 5'd4;
  localparam logic [4:0] S_AINIT  = 5'd5;
  localparam logic [4:0] S_ATEST  = 5'd6;
  localparam logic [4:0] S_AREAD  = 5'd7;
  localparam logic [4:0] S_ATAKE  = 5'd8;
  localparam logic [4:0] S_ATAKEW = 5'd9;
  localparam logic [4:0] S_AEXT   = 5'd10;
  localparam logic [4:0] S_ADONE  = 5'd11;
  localparam logic [4:0] S_SRD    = 5'd12;
  localparam logic [4:0] S_SCHK   = 5'd13;
  localparam logic [4:0] S_SNEW   = 5'd14;
  localparam logic [4:0] S_LRD1   = 5'd15;
  localparam logic [4:0] S_LCHK   = 5'd16;
  localparam logic [4:0] S_LWR    = 5'd17;
  localparam logic [4:0] S_MRD1   = 5'd18;
  localparam logic [4:0] S_MCHK   = 5'd19;
  localparam logic [4:0] S_MUSED  = 5'd20;
  localparam logic [4:0] S_RRD    = 5'd21;
  localparam logic [4:0] S_RWR    = 5'd22;
  localparam logic [4:0] S_RPRD   = 5'd23;
  localparam logic [4:0] S_RPCHK  = 5'd24;
  localparam logic [4:0] S_RPUSED = 5'd25;
  localparam logic [4:0] S_RECHK  = 5'd26;
  localparam logic [4:0] S_OUT    = 5'd27;

  logic [4:0] state_r, state_nxt;
  // return points of the split, link and merge sequences
  logic [4:0] sret_r, sret_nxt;
  logic [4:0] lret_r, lret_nxt;
  logic [4:0] mret_r, mret_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    sret_nxt  = sret_r;
    lret_nxt  = lret_r;
    mret_nxt  = mret_r;
    cmd       = CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_VINIT;
        end
      end
      // check that the pointer names a used block
      S_VINIT: begin
        cmd       = CMD_V_INIT;
        state_nxt = sts.v_skip ? S_DISP : S_VTEST;
      end
      S_VTEST: begin
        if (!sts.h_in || sts.h_gt) begin
          state_nxt = S_DISP;
        end else begin
          cmd       = CMD_RD_H;
          state_nxt = S_VREAD;
        end
      end
      S_VREAD: begin
        if (sts.h_eq) begin
          cmd       = CMD_V_EQ;
          state_nxt = S_DISP;
        end else if (sts.rd_small) begin
          state_nxt = S_DISP;
        end else begin
          cmd       = CMD_H_ADV;
          state_nxt = S_VTEST;
        end
      end
      // request dispatch
      S_DISP: begin
        case (sts.op)
          OP_ALLOC: begin
            cmd       = CMD_ALLOC_SET;
            state_nxt = S_AINIT;
          end
          OP_FREE: begin
            state_nxt = sts.vld ? S_RRD : S_OUT;
          end
          OP_REALLOC: begin
            if (!sts.pv) begin
              cmd       = CMD_ALLOC_SET;
              state_nxt = S_AINIT;
            end else if (!sts.vld) begin
              state_nxt = S_OUT;
            end else if (sts.rs_zero) begin
              state_nxt = S_RRD;
            end else begin
              cmd       = CMD_RD_TGT;
              state_nxt = S_RECHK;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      // best-fit scan, then take the best block or extend the heap
      S_AINIT: begin
        if (sts.areq_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd       = CMD_A_INIT;
          state_nxt = sts.brk_hdr ? S_ATEST : S_AEXT;
        end
      end
      S_ATEST: begin
        if (sts.h_in) begin
          cmd       = CMD_RD_H;
          state_nxt = S_AREAD;
        end else begin
          state_nxt = sts.found ? S_ATAKE : S_AEXT;
        end
      end
      S_AREAD: begin
        if (sts.rd_small) begin
          state_nxt = sts.found ? S_ATAKE : S_AEXT;
        end else begin
          cmd       = CMD_A_EVAL;
          state_nxt = S_ATEST;
        end
      end
      S_ATAKE: begin
        cmd       = CMD_TAKE_RD;
        state_nxt = S_ATAKEW;
      end
      S_ATAKEW: begin
        cmd       = CMD_TAKE_WR;
        sret_nxt  = S_ADONE;
        state_nxt = S_SRD;
      end
      S_AEXT: begin
        cmd       = sts.ext_fit ? CMD_EXT_WR : CMD_EXT_FAIL;
        state_nxt = S_ADONE;
      end
      S_ADONE: begin
        if (sts.op == OP_REALLOC && sts.pv && sts.ok) begin
          cmd       = CMD_MV_OK;
          state_nxt = S_RRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      // split off the tail of a block
      S_SRD: begin
        cmd       = CMD_S_RD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (sts.split_ok) begin
          cmd       = CMD_S_WR;
          state_nxt = S_SNEW;
        end else begin
          state_nxt = sret_r;
        end
      end
      S_SNEW: begin
        cmd = CMD_S_NEW;
        if (sts.last_is_sx) begin
          state_nxt = sret_r;
        end else begin
          lret_nxt  = sret_r;
          state_nxt = S_LRD1;
        end
      end
      // point the following block back
      S_LRD1: begin
        if (!sts.lk_ok1) begin
          state_nxt = lret_r;
        end else begin
          cmd       = CMD_L_RD1;
          state_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (sts.lk_ok2) begin
          cmd       = CMD_L_RD2;
          state_nxt = S_LWR;
        end else begin
          state_nxt = lret_r;
        end
      end
      S_LWR: begin
        cmd       = CMD_L_WR;
        state_nxt = lret_r;
      end
      // merge with a free following block
      S_MRD1: begin
        if (!sts.mg_ok1) begin
          state_nxt = mret_r;
        end else begin
          cmd       = CMD_M_RD1;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.mg_ok2) begin
          cmd       = CMD_M_RD2;
          state_nxt = S_MUSED;
        end else begin
          state_nxt = mret_r;
        end
      end
      S_MUSED: begin
        if (sts.rd_used) begin
          state_nxt = mret_r;
        end else begin
          cmd = CMD_M_WR;
          if (sts.last_is_mn) begin
            state_nxt = mret_r;
          end else begin
            lret_nxt  = mret_r;
            state_nxt = S_LRD1;
          end
        end
      end
      // release a block
      S_RRD: begin
        cmd       = CMD_RD_TGT;
        state_nxt = S_RWR;
      end
      S_RWR: begin
        cmd       = CMD_R_WR;
        mret_nxt  = S_RPRD;
        state_nxt = S_MRD1;
      end
      S_RPRD: begin
        cmd       = CMD_RD_TGT;
        state_nxt = S_RPCHK;
      end
      S_RPCHK: begin
        if (!sts.rd_pv) begin
          state_nxt = S_OUT;
        end else begin
          cmd       = CMD_RD_PREV;
          state_nxt = S_RPUSED;
        end
      end
      S_RPUSED: begin
        if (sts.rd_used) begin
          state_nxt = S_OUT;
        end else begin
          mret_nxt  = S_OUT;
          state_nxt = S_MRD1;
        end
      end
      // resize: shrink in place or move
      S_RECHK: begin
        if (sts.fits) begin
          cmd       = CMD_RE_SHR;
          sret_nxt  = S_OUT;
          state_nxt = S_SRD;
        end else begin
          cmd       = CMD_RE_MOV;
          state_nxt = S_AINIT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd       = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sret_r  <= S_OUT;
      lret_r  <= S_OUT;
      mret_r  <= S_OUT;
    end else begin
      state_r <= state_nxt;
      sret_r  <= sret_nxt;
      lret_r  <= lret_nxt;
      mret_r  <= mret_nxt;
    end
  end

endmodule

@@ sv/bfha_dp.sv @@
module bfha_dp
  import bfha_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CMD_W-1:0] cmd,
  output dp_sts_t          sts,
  input  logic [1:0]       in_op,
  input  logic             in_pointer_valid,
  input  logic [15:0]      in_body_offset,
  input  logic [16:0]      in_request_size,
  input  logic             cfg_wr_en,
  input  logic [16:0]      cfg_wr_data,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [15:0]      out_result_offset,
  output logic [1:0]       out_result_status,
  output logic             out_copy_needed,
  output logic [15:0]      out_copy_source,
  output logic [16:0]      out_copy_length
);

  localparam logic [18:0] HDR19 = 19'(HEADER_BYTES);
  localparam logic [16:0] LIM_MAX = 17'(HEAP_BYTES);

  // control state
  logic [16:0] brk_r, brk_nxt;
  logic [15:0] last_off_r, last_off_nxt;
  logic        last_vld_r, last_vld_nxt;
  logic [16:0] lim_r;
  logic        out_vld_r, out_vld_nxt;

  // request and working registers
  logic [1:0]  op_r, op_nxt;
  logic        pv_r, pv_nxt;
  logic [15:0] bo_r, bo_nxt;
  logic [16:0] rs_r, rs_nxt;
  logic [15:0] tgt_r, tgt_nxt;
  logic        vld_r, vld_nxt;
  logic [17:0] h_r, h_nxt;
  logic [15:0] best_r, best_nxt;
  logic [16:0] bbody_r, bbody_nxt;
  logic        found_r, found_nxt;
  logic [17:0] a_r, a_nxt;
  logic [17:0] areq_r, areq_nxt;
  logic [16:0] bs_r, bs_nxt;
  logic [15:0] sx_r, sx_nxt;
  logic [17:0] kp_r, kp_nxt;
  logic [15:0] lx_r, lx_nxt;
  logic [15:0] ln_r, ln_nxt;
  logic [15:0] mx_r, mx_nxt;
  logic [15:0] mn_r, mn_nxt;
  hdr_t        xd_r, xd_nxt;
  logic [15:0] off_r, off_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        cp_r, cp_nxt;
  logic [15:0] src_r, src_nxt;
  logic [16:0] len_r, len_nxt;
  logic [15:0] o_off_r, o_off_nxt;
  logic [1:0]  o_st_r, o_st_nxt;
  logic        o_cp_r, o_cp_nxt;
  logic [15:0] o_src_r, o_src_nxt;
  logic [16:0] o_len_r, o_len_nxt;

  // header memory
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_addr;
  hdr_t              mem_wd, rd;

  bfha_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (SLOTS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wd   (mem_wd),
    .rd   (rd)
  );

  // shared arithmetic
  logic [18:0] brk19, h19, rsz19, lk_n, mg_n, need, bs_ext;
  logic [16:0] body, eff_lim, rest;
  logic [15:0] n_split;
  logic        better;

  always_comb begin
    brk19   = {2'b0, brk_r};
    h19     = {1'b0, h_r};
    rsz19   = {2'b0, rd.size};
    body    = rd.size - 17'(HEADER_BYTES);
    better  = !rd.used && ({1'b0, body} >= a_r) && (!found_r || body < bbody_r);
    bs_ext  = rnd_up({1'b0, areq_r} + HDR19);
    eff_lim = (lim_r < LIM_MAX) ? lim_r : LIM_MAX;
    rest    = rd.size - kp_r[16:0];
    n_split = sx_r + kp_r[15:0];
    lk_n    = {3'b0, lx_r} + rsz19;
    mg_n    = {3'b0, mx_r} + rsz19;
    need    = rnd_up({2'b0, rs_r}) + HDR19;
  end

  // status toward the controller
  always_comb begin
    sts.op         = op_r;
    sts.pv         = pv_r;
    sts.vld        = vld_r;
    sts.rs_zero    = (rs_r == 17'd0);
    sts.v_skip     = !(pv_r && bo_r >= 16'(HEADER_BYTES));
    sts.h_in       = (h19 + HDR19) <= brk19;
    sts.h_gt       = h19 > {3'b0, tgt_r};
    sts.h_eq       = h19 == {3'b0, tgt_r};
    sts.rd_used    = rd.used;
    sts.rd_small   = rd.size < 17'(HEADER_BYTES);
    sts.rd_pv      = rd.pv;
    sts.found      = found_r;
    sts.areq_zero  = (areq_r == 18'd0);
    sts.brk_hdr    = brk_r >= 17'(HEADER_BYTES);
    sts.ext_fit    = (brk19 + bs_ext) <= {2'b0, eff_lim};
    sts.split_ok   = ({1'b0, rd.size} >= kp_r)
                     && (({1'b0, rd.size} - kp_r) >= 18'(HEADER_BYTES));
    sts.last_is_sx = last_vld_r && (sx_r == last_off_r);
    sts.lk_ok1     = ({3'b0, lx_r} + HDR19) < brk19;
    sts.lk_ok2     = (lk_n + HDR19) <= brk19;
    sts.mg_ok1     = ({3'b0, mx_r} + HDR19) < brk19;
    sts.mg_ok2     = (mg_n + HDR19) <= brk19;
    sts.last_is_mn = last_vld_r && (mn_r == last_off_r);
    sts.fits       = rsz19 >= need;
    sts.ok         = (st_r == ST_OK);
    sts.out_busy   = out_vld_r && out_stall;
  end

  // command execution
  always_comb begin
    brk_nxt      = brk_r;
    last_off_nxt = last_off_r;
    last_vld_nxt = last_vld_r;
    out_vld_nxt  = out_vld_r && out_stall;
    op_nxt = op_r;  pv_nxt = pv_r;  bo_nxt = bo_r;  rs_nxt = rs_r;
    tgt_nxt = tgt_r;  vld_nxt = vld_r;  h_nxt = h_r;  best_nxt = best_r;
    bbody_nxt = bbody_r;  found_nxt = found_r;  a_nxt = a_r;  areq_nxt = areq_r;
    bs_nxt = bs_r;  sx_nxt = sx_r;  kp_nxt = kp_r;  lx_nxt = lx_r;  ln_nxt = ln_r;
    mx_nxt = mx_r;  mn_nxt = mn_r;  xd_nxt = xd_r;
    off_nxt = off_r;  st_nxt = st_r;  cp_nxt = cp_r;  src_nxt = src_r;  len_nxt = len_r;
    o_off_nxt = o_off_r;  o_st_nxt = o_st_r;  o_cp_nxt = o_cp_r;
    o_src_nxt = o_src_r;  o_len_nxt = o_len_r;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = '0;
    mem_wd   = '0;
    case (cmd)
      CMD_LOAD: begin
        op_nxt  = in_op;
        pv_nxt  = in_pointer_valid;
        bo_nxt  = in_body_offset;
        rs_nxt  = in_request_size;
        tgt_nxt = in_body_offset - 16'(HEADER_BYTES);
        off_nxt = '0;
        st_nxt  = ST_NULL;
        cp_nxt  = 1'b0;
        src_nxt = '0;
        len_nxt = '0;
      end
      CMD_V_INIT: begin
        vld_nxt = 1'b0;
        h_nxt   = '0;
      end
      CMD_RD_H: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(h_r[15:0]);
      end
      CMD_V_EQ: begin
        vld_nxt = rd.used;
      end
      CMD_H_ADV: begin
        h_nxt = h_r + {1'b0, rd.size};
      end
      CMD_ALLOC_SET: begin
        areq_nxt = {1'b0, rs_r};
      end
      CMD_A_INIT: begin
        a_nxt     = 18'(rnd_up({1'b0, areq_r}));
        found_nxt = 1'b0;
        h_nxt     = '0;
      end
      CMD_A_EVAL: begin
        if (better) begin
          found_nxt = 1'b1;
          bbody_nxt = body;
          best_nxt  = h_r[15:0];
        end
        h_nxt = h_r + {1'b0, rd.size};
      end
      CMD_TAKE_RD: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(best_r);
      end
      CMD_TAKE_WR: begin
        mem_we      = 1'b1;
        mem_addr    = slot_of(best_r);
        mem_wd      = rd;
        mem_wd.used = 1'b1;
        sx_nxt      = best_r;
        kp_nxt      = a_r + 18'(HEADER_BYTES);
        off_nxt     = best_r + 16'(HEADER_BYTES);
        st_nxt      = ST_OK;
      end
      CMD_EXT_WR: begin
        mem_we       = 1'b1;
        mem_addr     = slot_of(brk_r[15:0]);
        mem_wd.size  = bs_ext[16:0];
        mem_wd.used  = 1'b1;
        mem_wd.prev  = last_off_r;
        mem_wd.pv    = last_vld_r;
        last_off_nxt = brk_r[15:0];
        last_vld_nxt = 1'b1;
        brk_nxt      = brk_r + bs_ext[16:0];
        off_nxt      = brk_r[15:0] + 16'(HEADER_BYTES);
        st_nxt       = ST_OK;
      end
      CMD_EXT_FAIL: begin
        st_nxt = ST_OOM;
      end
      CMD_S_RD: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(sx_r);
      end
      CMD_S_WR: begin
        mem_we      = 1'b1;
        mem_addr    = slot_of(sx_r);
        mem_wd      = rd;
        mem_wd.size = kp_r[16:0];
      end
      CMD_S_NEW: begin
        mem_we      = 1'b1;
        mem_addr    = slot_of(n_split);
        mem_wd.size = rest;
        mem_wd.used = 1'b0;
        mem_wd.prev = sx_r;
        mem_wd.pv   = 1'b1;
        lx_nxt      = n_split;
        if (last_vld_r && sx_r == last_off_r) begin
          last_off_nxt = n_split;
        end
      end
      CMD_L_RD1: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(lx_r);
      end
      CMD_L_RD2: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(lk_n[15:0]);
        ln_nxt   = lk_n[15:0];
      end
      CMD_L_WR: begin
        mem_we      = 1'b1;
        mem_addr    = slot_of(ln_r);
        mem_wd      = rd;
        mem_wd.prev = lx_r;
        mem_wd.pv   = 1'b1;
      end
      CMD_M_RD1: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(mx_r);
      end
      CMD_M_RD2: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(mg_n[15:0]);
        xd_nxt   = rd;
        mn_nxt   = mg_n[15:0];
      end
      CMD_M_WR: begin
        mem_we      = 1'b1;
        mem_addr    = slot_of(mx_r);
        mem_wd      = xd_r;
        mem_wd.size = xd_r.size + rd.size;
        lx_nxt      = mx_r;
        if (last_vld_r && mn_r == last_off_r) begin
          last_off_nxt = mx_r;
        end
      end
      CMD_RD_TGT: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(tgt_r);
      end
      CMD_R_WR: begin
        mem_we      = 1'b1;
        mem_addr    = slot_of(tgt_r);
        mem_wd      = rd;
        mem_wd.used = 1'b0;
        mx_nxt      = tgt_r;
      end
      CMD_RD_PREV: begin
        mem_re   = 1'b1;
        mem_addr = slot_of(rd.prev);
        mx_nxt   = rd.prev;
      end
      CMD_RE_SHR: begin
        sx_nxt  = tgt_r;
        kp_nxt  = need[17:0];
        off_nxt = bo_r;
        st_nxt  = ST_OK;
      end
      CMD_RE_MOV: begin
        bs_nxt   = rd.size;
        areq_nxt = 18'(rnd_up({2'b0, rs_r}));
      end
      CMD_MV_OK: begin
        cp_nxt  = 1'b1;
        src_nxt = bo_r;
        len_nxt = bs_r - 17'(HEADER_BYTES);
      end
      CMD_OUT: begin
        out_vld_nxt = 1'b1;
        o_off_nxt   = (st_r == ST_OK) ? off_r : 16'd0;
        o_st_nxt    = st_r;
        o_cp_nxt    = cp_r;
        o_src_nxt   = src_r;
        o_len_nxt   = len_r;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r      <= '0;
      last_off_r <= '0;
      last_vld_r <= 1'b0;
      lim_r      <= LIM_MAX;
      out_vld_r  <= 1'b0;
    end else begin
      brk_r      <= brk_nxt;
      last_off_r <= last_off_nxt;
      last_vld_r <= last_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt;  pv_r <= pv_nxt;  bo_r <= bo_nxt;  rs_r <= rs_nxt;
    tgt_r <= tgt_nxt;  vld_r <= vld_nxt;  h_r <= h_nxt;  best_r <= best_nxt;
    bbody_r <= bbody_nxt;  found_r <= found_nxt;  a_r <= a_nxt;  areq_r <= areq_nxt;
    bs_r <= bs_nxt;  sx_r <= sx_nxt;  kp_r <= kp_nxt;  lx_r <= lx_nxt;  ln_r <= ln_nxt;
    mx_r <= mx_nxt;  mn_r <= mn_nxt;  xd_r <= xd_nxt;
    off_r <= off_nxt;  st_r <= st_nxt;  cp_r <= cp_nxt;  src_r <= src_nxt;
    len_r <= len_nxt;
    o_off_r <= o_off_nxt;  o_st_r <= o_st_nxt;  o_cp_r <= o_cp_nxt;
    o_src_r <= o_src_nxt;  o_len_r <= o_len_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_result_offset = o_off_r;
  assign out_result_status = o_st_r;
  assign out_copy_needed   = o_cp_r;
  assign out_copy_source   = o_src_r;
  assign out_copy_length   = o_len_r;

endmodule

@@ sv/best_fit_heap_allocator_unit.sv @@
// Best-fit heap allocator, metadata only. Block headers live in a single-port
// header memory of 8192 entries (one per 8 heap bytes), so every header visit
// is a registered read. A request first checks the pointer by walking the
// blocks of the heap; an allocate then scans the blocks for the best fit, and
// split, merge and release finish with header updates.
// One request is worked at a time; the next is taken while the previous
// result still waits in the output register. heap_limit_bytes is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module best_fit_heap_allocator_unit
  import bfha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic        in_pointer_valid,
  input  logic [15:0] in_body_offset,
  input  logic [16:0] in_request_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result_offset,
  output logic [1:0]  out_result_status,
  output logic        out_copy_needed,
  output logic [15:0] out_copy_source,
  output logic [16:0] out_copy_length,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);

  logic [CMD_W-1:0] cmd;
  dp_sts_t          sts;

  // sequencer
  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // header memory and arithmetic
  bfha_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_pointer_valid  (in_pointer_valid),
    .in_body_offset    (in_body_offset),
    .in_request_size   (in_request_size),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_result_offset (out_result_offset),
    .out_result_status (out_result_status),
    .out_copy_needed   (out_copy_needed),
    .out_copy_source   (out_copy_source),
    .out_copy_length   (out_copy_length)
  );

endmodule

@@ sv/bfha_chk.sv @@
module bfha_chk
  import bfha_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_result_offset,
  input logic [1:0]  out_result_status,
  input logic        out_copy_needed
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // nothing offered right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // status is always a defined code
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_status == ST_OK || out_result_status == ST_NULL
                   || out_result_status == ST_OOM))
    else $error("undefined status code");

  // no offset without a returned block
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_status != ST_OK |-> out_result_offset == 16'd0)
    else $error("offset with null or failed result");

  // a copy is only asked for on success
  a_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_copy_needed |-> out_result_status == ST_OK)
    else $error("copy requested on failed result");

endmodule

bind best_fit_heap_allocator_unit bfha_chk u_bfha_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_offset (out_result_offset),
  .out_result_status (out_result_status),
  .out_copy_needed   (out_copy_needed)
);
